@@ rtl/tcdq_pkg.sv @@
// Package for the timed callback deadline queue.
// Holds table sizes, register indexes, result codes, entry and state types.
// No dependencies.
package tcdq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic REG_TICK_MS    = 1'b0;
    localparam logic REG_ERR_RELOAD = 1'b1;

    // Input operation codes
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    typedef enum logic [1:0] {
        KIND_EXPIRED  = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_REJECTED = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] deadline;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_POP_RD,
        ST_POP_CMP,
        ST_EMIT
    } state_t;

endpackage

@@ rtl/tcdq_if.sv @@
// Channel interfaces for the timed callback deadline queue.
// Request channel carries tick/schedule beats, response channel carries results.
// Depends on nothing.
interface tcdq_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  callback_id;
    logic [31:0] delay_ms;

    modport source (output valid, output op, output callback_id, output delay_ms,
                    input ready);
    modport sink   (input valid, input op, input callback_id, input delay_ms,
                    output ready);
endinterface

interface tcdq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  fired_id;
    logic [31:0] deadline;
    logic        last;

    modport source (output valid, output kind, output fired_id, output deadline,
                    output last, input ready);
    modport sink   (input valid, input kind, input fired_id, input deadline,
                    input last, output ready);
endinterface

@@ rtl/timed_callback_deadline_queue.sv @@
// Timed callback deadline queue. Schedule: the walk moves each earlier entry one slot (k =
// entries moved, 0..15) until it reaches the head or a compare stops it; a full table is
// rejected without a walk. Tick: the n expired entries are emitted, the last one flagged;
// one memory read per compare sets the pace. One item is in work at a time; the next beat
// is taken the cycle after the item ends.
// Reset (async, active low): clock, count, countdown zero, tick_ms 1; table left undefined.
// Uses tcdq_pkg and tcdq_if.
module timed_callback_deadline_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [7:0]               cfg_wdata,
    tcdq_req_if.sink                 req,
    tcdq_rsp_if.source               rsp
);
    import tcdq_pkg::*;

    // Table memory, latest deadline at index 0
    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    state_t            state_reg, state_next;
    logic [31:0]       now_reg, now_next;
    logic [7:0]        cnt_down_reg, cnt_down_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [7:0]        tick_ms_reg, tick_ms_next;
    logic [7:0]        err_reload_reg, err_reload_next;
    entry_t            new_reg, new_next;
    kind_t             res_kind_reg, res_kind_next;
    logic              pend_valid_reg, pend_valid_next;
    entry_t            pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    entry_t            out_reg, out_next;
    logic              out_last_reg, out_last_next;

    logic              slot_free;
    logic              due;
    logic              shift_up;
    logic              accept;
    logic [7:0]        cnt_dec;
    logic              corr;
    logic [31:0]       now_plus;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign due       = rd_data_reg.deadline <= now_reg;
    assign shift_up  = rd_data_reg.deadline < new_reg.deadline;
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign cnt_dec   = cnt_down_reg - 8'd1;
    assign corr      = (err_reload_reg != 8'd0) && (cnt_dec == 8'd0);
    assign now_plus  = now_reg + {24'd0, tick_ms_reg};

    // Drive the response channel from the output register
    assign rsp.valid    = out_valid_reg;
    assign rsp.kind     = out_kind_reg;
    assign rsp.fired_id = out_reg.id;
    assign rsp.deadline = out_reg.deadline;
    assign rsp.last     = out_last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.op == OP_SCHEDULE)
                    begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                            state_next = ST_EMIT;
                        else
                            state_next = ST_INS_RD;
                    end
                    else
                        state_next = ST_POP_RD;
                end
            end
            ST_INS_RD:
            begin
                if (pos_reg == '0)
                    state_next = ST_EMIT;
                else
                    state_next = ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                if (shift_up)
                    state_next = ST_INS_RD;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            ST_POP_RD:
            begin
                if (count_reg != '0)
                    state_next = ST_POP_CMP;
                else if (!pend_valid_reg || slot_free)
                    state_next = ST_IDLE;
            end
            ST_POP_CMP:
            begin
                if (due)
                begin
                    if (!pend_valid_reg || slot_free)
                        state_next = ST_POP_RD;
                end
                else if (!pend_valid_reg || slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory access and result emission
    always_comb
    begin
        now_next        = now_reg;
        cnt_down_next   = cnt_down_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        tick_ms_next    = tick_ms_reg;
        err_reload_next = err_reload_reg;
        new_next        = new_reg;
        res_kind_next   = res_kind_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_kind_next   = out_kind_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = new_reg;

        // Drop the output beat once taken
        out_valid_next = out_valid_reg && !rsp.ready;

        // Take configuration writes
        if (cfg_we)
        begin
            if (cfg_index == REG_TICK_MS)
                tick_ms_next = cfg_wdata;
            else
            begin
                err_reload_next = cfg_wdata;
                cnt_down_next   = cfg_wdata;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.op == OP_SCHEDULE)
                    begin
                        new_next.id       = req.callback_id;
                        new_next.deadline = now_reg + req.delay_ms;
                        pos_next          = count_reg;
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                            res_kind_next = KIND_REJECTED;
                        else
                            res_kind_next = KIND_ACCEPTED;
                    end
                    else
                    begin
                        // Advance the clock, with a correction tick when due
                        pend_valid_next = 1'b0;
                        if (err_reload_reg != 8'd0)
                        begin
                            if (corr)
                                cnt_down_next = err_reload_reg;
                            else
                                cnt_down_next = cnt_dec;
                        end
                        if (corr)
                            now_next = now_plus + {24'd0, tick_ms_reg};
                        else
                            now_next = now_plus;
                    end
                end
            end
            ST_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = new_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(pos_reg - CNT_W'(1));
                end
            end
            ST_INS_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(pos_reg);
                if (shift_up)
                begin
                    // Move the earlier entry one slot toward the tail
                    wr_data  = rd_data_reg;
                    pos_next = pos_reg - CNT_W'(1);
                end
                else
                begin
                    wr_data    = new_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_next       = new_reg;
                    out_last_next  = 1'b1;
                end
            end
            ST_POP_RD:
            begin
                if (count_reg != '0)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(count_reg - CNT_W'(1));
                end
                else if (pend_valid_reg && slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_EXPIRED;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            ST_POP_CMP:
            begin
                if (!pend_valid_reg || slot_free)
                begin
                    // Emit the held entry; it is final when nothing more is due
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_EXPIRED;
                        out_next       = pend_reg;
                        out_last_next  = !due;
                    end
                    if (due)
                    begin
                        pend_valid_next = 1'b1;
                        pend_next       = rd_data_reg;
                        count_next      = count_reg - CNT_W'(1);
                    end
                    else
                        pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            cnt_down_reg   <= '0;
            count_reg      <= '0;
            tick_ms_reg    <= 8'd1;
            err_reload_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            cnt_down_reg   <= cnt_down_next;
            count_reg      <= count_next;
            tick_ms_reg    <= tick_ms_next;
            err_reload_reg <= err_reload_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        new_reg      <= new_next;
        res_kind_reg <= res_kind_next;
        pend_reg     <= pend_next;
        out_kind_reg <= out_kind_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule
